/* src/tpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared types and constants of the trapezoid profile pulse generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

   localparam int FractionBitsDefault = 16;

   localparam int PeakWidth     = 32;
   localparam int TickWidth     = 16;
   localparam int PosWidth      = 48;
   localparam int CountWidth    = 16;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 32;

   // Divider: |peak * m| < 2^48, quotient < 2^31, divisor 2R < 2^17
   localparam int MultWidth = 18;
   localparam int ProdWidth = PeakWidth + MultWidth;
   localparam int DivWidth  = TickWidth + 1;
   localparam int QuotWidth = PeakWidth - 1;
   localparam int IterWidth = $clog2(QuotWidth + 1);

   typedef enum logic [CsrIndexWidth-1:0] {
      REG_PEAK_RATE   = 2'd0,
      REG_RAMP_TICKS  = 2'd1,
      REG_TOTAL_TICKS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_SETUP,
      OP_MUL,
      OP_ABS,
      OP_DIV,
      OP_SIGN,
      OP_ROUND,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   take;
   } ctrl_type;

   typedef struct packed {
      logic idle_axis;
      logic skip_div;
      logic div_more;
      logic out_busy;
   } status_type;

endpackage

/* src/tpg_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module tpg_seq import tpg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output logic       req_stall,
   output ctrl_type   ctrl
);

   localparam int StepWidth = 3;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_IDLE_AXIS,
      COND_SKIP_DIV,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type                 op;
      cond_type               cond;
      logic [StepWidth-1:0]   target;
   } uword_type;

   localparam logic [StepWidth-1:0] S_WAIT  = 3'd0;
   localparam logic [StepWidth-1:0] S_SETUP = 3'd1;
   localparam logic [StepWidth-1:0] S_MUL   = 3'd2;
   localparam logic [StepWidth-1:0] S_ABS   = 3'd3;
   localparam logic [StepWidth-1:0] S_DIV   = 3'd4;
   localparam logic [StepWidth-1:0] S_SIGN  = 3'd5;
   localparam logic [StepWidth-1:0] S_ROUND = 3'd6;
   localparam logic [StepWidth-1:0] S_EMIT  = 3'd7;

   function automatic uword_type ucode(input logic [StepWidth-1:0] addr);
      uword_type w;
      case (addr)
         S_WAIT:  w = '{op: OP_WAIT,  cond: COND_NO_REQ,    target: S_WAIT};
         S_SETUP: w = '{op: OP_SETUP, cond: COND_IDLE_AXIS, target: S_EMIT};
         S_MUL:   w = '{op: OP_MUL,   cond: COND_SKIP_DIV,  target: S_ROUND};
         S_ABS:   w = '{op: OP_ABS,   cond: COND_NEVER,     target: S_WAIT};
         S_DIV:   w = '{op: OP_DIV,   cond: COND_DIV_MORE,  target: S_DIV};
         S_SIGN:  w = '{op: OP_SIGN,  cond: COND_NEVER,     target: S_WAIT};
         S_ROUND: w = '{op: OP_ROUND, cond: COND_NEVER,     target: S_WAIT};
         S_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_BUSY,  target: S_EMIT};
         default: w = '{op: OP_WAIT,  cond: COND_NEVER,     target: S_WAIT};
      endcase
      return w;
   endfunction

   logic [StepWidth-1:0] step_ff;
   logic [StepWidth-1:0] step_in;
   uword_type            uw;
   logic                 jump;

   always_comb begin
      uw = ucode(step_ff);
      case (uw.cond)
         COND_NEVER:     jump = 1'b0;
         COND_NO_REQ:    jump = !req_valid;
         COND_IDLE_AXIS: jump = status.idle_axis;
         COND_SKIP_DIV:  jump = status.skip_div;
         COND_DIV_MORE:  jump = status.div_more;
         COND_OUT_BUSY:  jump = status.out_busy;
         default:        jump = 1'b0;
      endcase
      // EMIT is the last word; falling through wraps to WAIT
      step_in = jump ? uw.target : step_ff + StepWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign req_stall = (uw.op != OP_WAIT);
   assign ctrl.op   = uw.op;
   assign ctrl.take = (uw.op == OP_WAIT) && req_valid;

endmodule

/* src/tpg_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_datapath
// Profile registers, multiplier, shift-subtract divider, rounding with
// residue carry, position accumulator and the result word register.
// ----------------------------------------------------------------------------
module tpg_datapath import tpg_pkg::*; #(
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_type                      ctrl,
   output status_type                    status,
   input  logic                          csr_wr_en,
   input  logic [CsrIndexWidth-1:0]      csr_index,
   input  logic [CsrDataWidth-1:0]       csr_wr_data,
   input  logic [TickWidth-1:0]          req_step_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CountWidth-1:0]         rsp_pulse_count,
   output logic                          rsp_direction,
   output logic signed [PosWidth-1:0]    rsp_position
);

   localparam int ResW   = FRACTION_BITS + 2;
   localparam int WholeW = PeakWidth - FRACTION_BITS;
   localparam int CntW   = (WholeW + 2 > CountWidth + 1) ? WholeW + 2 : CountWidth + 1;
   localparam int FracXW = FRACTION_BITS + 4;

   localparam logic signed [ResW-1:0] One      = ResW'(1 << FRACTION_BITS);
   localparam logic signed [ResW-1:0] MinusOne = -One;
   localparam logic [FracXW-1:0]      SevenOne = FracXW'(7 << FRACTION_BITS);

   // profile registers
   logic signed [PeakWidth-1:0] peak_ff;
   logic [TickWidth-1:0]        ramp_ff;
   logic [TickWidth-1:0]        total_ff;

   // state
   logic signed [ResW-1:0]      residue_ff, residue_in;
   logic signed [PosWidth-1:0]  pos_ff, pos_in;

   // working registers
   logic [TickWidth-1:0]        k_ff, k_in;
   logic signed [MultWidth-1:0] mult_ff, mult_in;
   logic [DivWidth-1:0]         div_ff, div_in;
   logic                        skip_ff, skip_in;
   logic signed [ProdWidth-1:0] prod_ff, prod_in;
   logic                        neg_ff, neg_in;
   logic [DivWidth-1:0]         rem_ff, rem_in;
   logic [QuotWidth-1:0]        sh_ff, sh_in;
   logic [IterWidth-1:0]        iter_ff, iter_in;
   logic signed [PeakWidth-1:0] d_ff, d_in;
   logic [CountWidth-1:0]       count_ff, count_in;
   logic                        dir_ff, dir_in;

   // result word
   logic                        rsp_valid_ff;
   logic [CountWidth-1:0]       rsp_count_ff;
   logic                        rsp_dir_ff;
   logic signed [PosWidth-1:0]  rsp_pos_ff;
   logic                        out_busy;
   logic                        emit;

   // setup terms
   logic [TickWidth-1:0]        r_eff;
   logic [TickWidth:0]          k_plus_r;
   logic                        in_ramp, in_cruise, in_down;
   logic signed [MultWidth-1:0] m_ramp, m_down;

   // divider terms
   logic [ProdWidth-1:0]        mag;
   logic [DivWidth:0]           rem_sh, diff;
   logic                        ge;

   // rounding terms
   logic [PeakWidth-1:0]        d_mag;
   logic [WholeW-1:0]           whole;
   logic [FRACTION_BITS-1:0]    frac;
   logic [FracXW-1:0]           frac_x10;
   logic                        round_up;
   logic signed [ResW-1:0]      frac_s, res_a;
   logic [CntW-1:0]             cnt_a, cnt_b;

   assign out_busy = rsp_valid_ff && rsp_stall;
   assign emit     = (ctrl.op == OP_EMIT) && !out_busy;

   always_comb begin
      r_eff     = (ramp_ff == '0) ? TickWidth'(1) : ramp_ff;
      in_ramp   = (k_ff <= r_eff);
      k_plus_r  = {1'b0, k_ff} + {1'b0, r_eff};
      // k <= T - R without going negative
      in_cruise = (k_plus_r <= {1'b0, total_ff});
      in_down   = (k_ff <= total_ff);
      m_ramp    = $signed({1'b0, k_ff, 1'b0}) - MultWidth'(1);
      m_down    = $signed({1'b0, total_ff - k_ff, 1'b1});

      mag    = prod_ff[ProdWidth-1] ? ProdWidth'(-prod_ff) : ProdWidth'(prod_ff);
      rem_sh = {rem_ff, sh_ff[QuotWidth-1]};
      diff   = rem_sh - {1'b0, div_ff};
      ge     = !diff[DivWidth];

      d_mag    = d_ff[PeakWidth-1] ? PeakWidth'(-d_ff) : PeakWidth'(d_ff);
      whole    = d_mag[PeakWidth-1:FRACTION_BITS];
      frac     = d_mag[FRACTION_BITS-1:0];
      frac_x10 = FracXW'(frac) * FracXW'(10);
      round_up = (frac_x10 > SevenOne);
      frac_s   = $signed({2'b00, frac});
      res_a    = residue_ff + (round_up ? frac_s - One : frac_s);
      cnt_a    = CntW'(whole) + CntW'(round_up);
   end

   always_comb begin
      k_in       = k_ff;
      mult_in    = mult_ff;
      div_in     = div_ff;
      skip_in    = skip_ff;
      prod_in    = prod_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      sh_in      = sh_ff;
      iter_in    = iter_ff;
      d_in       = d_ff;
      count_in   = count_ff;
      dir_in     = dir_ff;
      residue_in = residue_ff;
      pos_in     = pos_ff;
      cnt_b      = cnt_a;
      if (ctrl.take) begin
         k_in = req_step_index;
      end
      case (ctrl.op)
         OP_SETUP: begin
            div_in   = {r_eff, 1'b0};
            count_in = '0;
            dir_in   = 1'b0;
            if (in_ramp) begin
               mult_in = m_ramp;
               skip_in = 1'b0;
            end else if (in_cruise) begin
               d_in    = peak_ff;
               skip_in = 1'b1;
            end else if (in_down) begin
               mult_in = m_down;
               skip_in = 1'b0;
            end else begin
               d_in    = '0;
               skip_in = 1'b1;
            end
         end
         OP_MUL: begin
            prod_in = ProdWidth'(peak_ff) * ProdWidth'(mult_ff);
         end
         OP_ABS: begin
            // quotient fits QuotWidth bits, so the top bits start below the divisor
            neg_in  = prod_ff[ProdWidth-1];
            rem_in  = mag[QuotWidth+DivWidth-1:QuotWidth];
            sh_in   = mag[QuotWidth-1:0];
            iter_in = IterWidth'(QuotWidth);
         end
         OP_DIV: begin
            rem_in  = ge ? diff[DivWidth-1:0] : rem_sh[DivWidth-1:0];
            sh_in   = {sh_ff[QuotWidth-2:0], ge};
            iter_in = iter_ff - IterWidth'(1);
         end
         OP_SIGN: begin
            d_in = neg_ff ? -$signed({1'b0, sh_ff}) : $signed({1'b0, sh_ff});
         end
         OP_ROUND: begin
            pos_in = pos_ff + PosWidth'(d_ff);
            dir_in = !d_ff[PeakWidth-1] && (d_ff != '0);
            if (res_a >= One) begin
               residue_in = res_a - One;
               cnt_b      = cnt_a + CntW'(1);
            end else if ((res_a <= MinusOne) && (cnt_a != '0)) begin
               residue_in = res_a + One;
               cnt_b      = cnt_a - CntW'(1);
            end else begin
               residue_in = res_a;
            end
            count_in = (|cnt_b[CntW-1:CountWidth]) ? '1 : cnt_b[CountWidth-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         ramp_ff      <= TickWidth'(1);
         total_ff     <= '0;
         residue_ff   <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_PEAK_RATE:   peak_ff  <= $signed(csr_wr_data[PeakWidth-1:0]);
               REG_RAMP_TICKS:  ramp_ff  <= csr_wr_data[TickWidth-1:0];
               REG_TOTAL_TICKS: total_ff <= csr_wr_data[TickWidth-1:0];
               default: begin
               end
            endcase
         end
         residue_ff <= residue_in;
         pos_ff     <= pos_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      mult_ff  <= mult_in;
      div_ff   <= div_in;
      skip_ff  <= skip_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      sh_ff    <= sh_in;
      iter_ff  <= iter_in;
      d_ff     <= d_in;
      count_ff <= count_in;
      dir_ff   <= dir_in;
      if (emit) begin
         rsp_count_ff <= count_ff;
         rsp_dir_ff   <= dir_ff;
         rsp_pos_ff   <= pos_ff;
      end
   end

   assign status.idle_axis = (peak_ff == '0);
   assign status.skip_div  = skip_ff;
   assign status.div_more  = (iter_ff != IterWidth'(1));
   assign status.out_busy  = out_busy;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pulse_count = rsp_count_ff;
   assign rsp_direction   = rsp_dir_ff;
   assign rsp_position    = rsp_pos_ff;

endmodule

/* src/trapezoid_profile_pulse_generator_top.sv */
`timescale 1ns / 1ps
// Steps per word: setup; if peak_rate is 0, straight to emit. Else multiply; a ramp
//   tick (up or down) then runs magnitude, shift-subtract divider and sign, a cruise
//   or after-end tick skips them; then round and emit. The next word is taken once
//   the result is in the output register, which may still be waiting on rsp_stall.
// Reset (synchronous): position and residue clear, peak_rate 0, ramp_ticks 1,
//   total_ticks 0, sequencer back to its wait step.
// ----------------------------------------------------------------------------
// trapezoid_profile_pulse_generator_top
// Per-tick trapezoidal profile step generator for one axis.
// ----------------------------------------------------------------------------
module trapezoid_profile_pulse_generator_top import tpg_pkg::*; #(
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CsrIndexWidth-1:0]      csr_index,
   input  logic [CsrDataWidth-1:0]       csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [TickWidth-1:0]          req_step_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CountWidth-1:0]         rsp_pulse_count,
   output logic                          rsp_direction,
   output logic signed [PosWidth-1:0]    rsp_position
);

   ctrl_type   ctrl;
   status_type status;

   tpg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .ctrl      (ctrl)
   );

   tpg_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_step_index  (req_step_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pulse_count (rsp_pulse_count),
      .rsp_direction   (rsp_direction),
      .rsp_position    (rsp_position)
   );

endmodule
